>>> hdl/esp_pkg.sv
// Shared types, constants and the control store for the encoder speed PID block.
// Used by every module in hdl/; depends on nothing else.
package esp_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int SUM_WIDTH_DEF = 48;

  localparam int CD_W    = 16;
  localparam int GAIN_W  = 32;
  localparam int SPEED_W = 32;
  localparam int MAX_W   = 16;
  localparam int SCALE_W = 24;
  localparam int DRIVE_W = 17;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_TARGET     = 3'd3,
    REG_MAX_DRIVE  = 3'd4,
    REG_SPEED_SCL  = 3'd5
  } cfg_reg_e;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 32'd655360;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 32'd6554;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 32'd0;
  localparam logic [SPEED_W-1:0] TARGET_RST     = 32'd51200;
  localparam logic [MAX_W-1:0]   MAX_DRIVE_RST  = 16'd2400;
  localparam logic [SCALE_W-1:0] SPEED_SCL_RST  = 24'd419565;

  typedef enum logic [2:0] {
    M_SPEED = 3'd0,
    M_KP_E  = 3'd1,
    M_KI_LO = 3'd2,
    M_KI_HI = 3'd3,
    M_KD_D  = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD    = 2'd2,
    ACC_ADD_HI = 2'd3
  } acc_op_e;

  typedef enum logic [2:0] {
    DP_NOP   = 3'd0,
    DP_LOAD  = 3'd1,
    DP_SPEED = 3'd2,
    DP_ERR   = 3'd3,
    DP_INTEG = 3'd4,
    DP_ABS   = 3'd5,
    DP_EMIT  = 3'd6
  } dp_op_e;

  typedef enum logic [1:0] {
    J_NONE     = 2'd0,
    J_NO_INPUT = 2'd1,
    J_OUT_BUSY = 2'd2
  } jmp_cond_e;

  localparam int PROG_LEN = 12;
  localparam int STEP_W   = $clog2(PROG_LEN);

  typedef struct packed {
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    dp_op_e           dp_op;
    jmp_cond_e        jmp_cond;
    logic [STEP_W-1:0] jmp_addr;
    logic             eop;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
  } seq_status_t;

  localparam logic [STEP_W-1:0] STEP_LOAD = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(11);

  localparam ctrl_t PROGRAM [PROG_LEN] = '{
    '{M_SPEED, ACC_HOLD,   DP_LOAD,  J_NO_INPUT, STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_SPEED, J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_ERR,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_INTEG, J_NONE,     STEP_LOAD, 1'b0},
    '{M_KP_E,  ACC_HOLD,   DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_KI_LO, ACC_LOAD,   DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_KI_HI, ACC_ADD,    DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_KD_D,  ACC_ADD_HI, DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_ADD,    DP_NOP,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_ABS,   J_NONE,     STEP_LOAD, 1'b0},
    '{M_SPEED, ACC_HOLD,   DP_EMIT,  J_OUT_BUSY, STEP_EMIT, 1'b1}
  };

endpackage

>>> hdl/esp_mul.sv
// Shared 33x33 signed multiplier with registered product.
// Depends on esp_pkg.
module esp_mul
  import esp_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> hdl/esp_seq.sv
// Step counter and control store; jumps on input/output handshake status.
// Depends on esp_pkg.
module esp_seq
  import esp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ctrl_t       ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  ctrl_t             cw;
  logic              take;

  assign cw = PROGRAM[step_q];

  always_comb begin
    unique case (cw.jmp_cond)
      J_NO_INPUT: take = !status_i.in_valid;
      J_OUT_BUSY: take = status_i.out_busy;
      default:    take = 1'b0;
    endcase
    if (take) begin
      step_d = cw.jmp_addr;
    end else if (cw.eop) begin
      step_d = STEP_LOAD;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = cw;

endmodule

>>> hdl/esp_dp.sv
// PID datapath: speed scaling, error, saturating integral, product accumulation, clamp.
// Depends on esp_pkg and esp_mul.
module esp_dp
  import esp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_t                      ctrl_i,
  input  logic                       accept_i,
  input  logic signed [CD_W-1:0]     cd_i,
  input  logic signed [GAIN_W-1:0]   kp_i,
  input  logic signed [GAIN_W-1:0]   ki_i,
  input  logic signed [GAIN_W-1:0]   kd_i,
  input  logic signed [SPEED_W-1:0]  target_i,
  input  logic [MAX_W-1:0]           max_drive_i,
  input  logic [SCALE_W-1:0]         scale_i,
  output logic signed [DRIVE_W-1:0]  drive_o,
  output logic signed [SPEED_W-1:0]  speed_o
);

  localparam int SPD_W  = CD_W + SCALE_W + 1;
  localparam int SPD_SH = 16 - FRAC_BITS;
  localparam logic signed [SPD_W-1:0] SPD_BIAS = SPD_W'((64'(1) << SPD_SH) - 64'(1));
  localparam int ACC_W  = SUM_WIDTH + 35;
  localparam int DRV_SH = 16 + FRAC_BITS;
  localparam int Q_W    = ACC_W - DRV_SH;
  localparam logic signed [SPEED_W-1:0] S32_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] S32_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [CD_W-1:0]      cd_q;
  logic signed [SPEED_W-1:0]   speed_q, speed_d;
  logic signed [SPEED_W-1:0]   e_q, e_d;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic signed [SPEED_W-1:0]   prev_q;
  logic signed [MUL_W-1:0]     diff_q;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic [ACC_W-1:0]            mag_q;
  logic                        neg_q;

  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     prod_ext;
  logic signed [SUM_WIDTH-1:0] sum_hi_w;

  logic signed [SPD_W-1:0]     spd_raw, spd_bias, spd_adj, spd_shr;
  logic signed [SPEED_W:0]     err_w;
  logic signed [SUM_WIDTH:0]   sum_w;
  logic [Q_W-1:0]              q_hi;
  logic [MAX_W-1:0]            q_clamp;
  logic [DRIVE_W-1:0]          q_ext;

  esp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign sum_hi_w = sum_q >>> 32;

  always_comb begin
    unique case (ctrl_i.mul_sel)
      M_KP_E: begin
        mul_a = MUL_W'(kp_i);
        mul_b = MUL_W'(e_q);
      end
      M_KI_LO: begin
        mul_a = MUL_W'(ki_i);
        mul_b = signed'({1'b0, sum_q[31:0]});
      end
      M_KI_HI: begin
        mul_a = MUL_W'(ki_i);
        mul_b = MUL_W'(sum_hi_w);
      end
      M_KD_D: begin
        mul_a = MUL_W'(kd_i);
        mul_b = diff_q;
      end
      default: begin
        mul_a = MUL_W'(cd_q);
        mul_b = signed'({{(MUL_W-SCALE_W){1'b0}}, scale_i});
      end
    endcase
  end

  // speed: truncate toward zero, then saturate to 32 bits
  always_comb begin
    spd_raw  = signed'(prod[SPD_W-1:0]);
    spd_bias = spd_raw[SPD_W-1] ? SPD_BIAS : SPD_W'(0);
    spd_adj  = spd_raw + spd_bias;
    spd_shr  = spd_adj >>> SPD_SH;
    if (&spd_shr[SPD_W-1:SPEED_W-1] || ~|spd_shr[SPD_W-1:SPEED_W-1]) begin
      speed_d = spd_shr[SPEED_W-1:0];
    end else if (spd_shr[SPD_W-1]) begin
      speed_d = S32_MIN;
    end else begin
      speed_d = S32_MAX;
    end
  end

  always_comb begin
    err_w = (SPEED_W+1)'(target_i) - (SPEED_W+1)'(speed_q);
    if (err_w[SPEED_W] == err_w[SPEED_W-1]) begin
      e_d = err_w[SPEED_W-1:0];
    end else if (err_w[SPEED_W]) begin
      e_d = S32_MIN;
    end else begin
      e_d = S32_MAX;
    end
  end

  always_comb begin
    sum_w = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(e_q);
    if (sum_w[SUM_WIDTH] == sum_w[SUM_WIDTH-1]) begin
      sum_d = sum_w[SUM_WIDTH-1:0];
    end else if (sum_w[SUM_WIDTH]) begin
      sum_d = SUM_MIN;
    end else begin
      sum_d = SUM_MAX;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_comb begin
    unique case (ctrl_i.acc_op)
      ACC_LOAD:   acc_d = prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      ACC_ADD_HI: acc_d = acc_q + (prod_ext <<< 32);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (ctrl_i.dp_op == DP_INTEG) begin
      sum_q  <= sum_d;
      prev_q <= e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cd_q <= cd_i;
    end
    if (ctrl_i.dp_op == DP_SPEED) begin
      speed_q <= speed_d;
    end
    if (ctrl_i.dp_op == DP_ERR) begin
      e_q <= e_d;
    end
    if (ctrl_i.dp_op == DP_INTEG) begin
      diff_q <= MUL_W'(e_q) - MUL_W'(prev_q);
    end
    if (ctrl_i.dp_op == DP_ABS) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= acc_q[ACC_W-1] ? unsigned'(-acc_q) : unsigned'(acc_q);
    end
    acc_q <= acc_d;
  end

  always_comb begin
    q_hi = mag_q[ACC_W-1:DRV_SH];
    if (q_hi > Q_W'(max_drive_i)) begin
      q_clamp = max_drive_i;
    end else begin
      q_clamp = q_hi[MAX_W-1:0];
    end
    q_ext = {1'b0, q_clamp};
  end

  assign drive_o = neg_q ? signed'(-q_ext) : signed'(q_ext);
  assign speed_o = speed_q;

endmodule

>>> hdl/encoder_speed_pid_top.sv
// Encoder speed PID controller: config registers, stream ports, output register.
// The result is registered into the output register at the emit step of the pass.
// A new input item is taken only at the load step, after a full pass of the control
// store over the shared multiplier; the pass stalls while the output is not drained.
// Reset: gains and limits return to defaults, integral and last error clear.
// Depends on esp_pkg, esp_seq, esp_dp, esp_mul.
module encoder_speed_pid_top
  import esp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [15:0] count_delta
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata   // [16:0] drive, [48:17] speed, zero fill
);

  logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [SPEED_W-1:0] target_q;
  logic [MAX_W-1:0]   max_q;
  logic [SCALE_W-1:0] scale_q;

  ctrl_t                      ctrl;
  seq_status_t                status;
  logic                       accept;
  logic                       emit;
  logic                       out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0]  drive_w;
  logic signed [SPEED_W-1:0]  speed_w;
  logic [DRIVE_W-1:0]         drive_q;
  logic [SPEED_W-1:0]         speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= PROP_GAIN_RST;
      ki_q     <= INTEG_GAIN_RST;
      kd_q     <= DERIV_GAIN_RST;
      target_q <= TARGET_RST;
      max_q    <= MAX_DRIVE_RST;
      scale_q  <= SPEED_SCL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROP_GAIN:  kp_q     <= cfg_wdata_i;
        REG_INTEG_GAIN: ki_q     <= cfg_wdata_i;
        REG_DERIV_GAIN: kd_q     <= cfg_wdata_i;
        REG_TARGET:     target_q <= cfg_wdata_i;
        REG_MAX_DRIVE:  max_q    <= cfg_wdata_i[MAX_W-1:0];
        REG_SPEED_SCL:  scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready   = (ctrl.dp_op == DP_LOAD);
  assign accept          = s_axis_tvalid && s_axis_tready;
  assign status.in_valid = s_axis_tvalid;
  assign status.out_busy = out_valid_q && !m_axis_tready;
  assign emit            = (ctrl.dp_op == DP_EMIT) && !status.out_busy;

  esp_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  esp_dp #(
    .FRAC_BITS (FRAC_BITS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .accept_i    (accept),
    .cd_i        (signed'(s_axis_tdata)),
    .kp_i        (signed'(kp_q)),
    .ki_i        (signed'(ki_q)),
    .kd_i        (signed'(kd_q)),
    .target_i    (signed'(target_q)),
    .max_drive_i (max_q),
    .scale_i     (scale_q),
    .drive_o     (drive_w),
    .speed_o     (speed_w)
  );

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      drive_q <= drive_w;
      speed_q <= speed_w;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, speed_q, drive_q};

endmodule
